// ===== src/flr_pkg.sv =====
`timescale 1ns / 1ps

package flr_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_START_CHAR    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ACCEPT_CHAR   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_REJECT_CHAR   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_CHECK_SEED    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_LENGTH_LIMIT  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_TIMEOUT_ON    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_TIMEOUT_TICKS = 3'd6;

   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_BYTE  = 2'd1;
   localparam logic [1:0] KIND_TICK  = 2'd2;

   typedef struct packed {
      logic [7:0]  start_char;
      logic [7:0]  accept_char;
      logic [7:0]  reject_char;
      logic [7:0]  check_seed;
      logic [7:0]  length_limit;
      logic        timeout_on;
      logic [15:0] timeout_ticks;
   } cfg_type;

endpackage

// ===== src/framed_link_receiver_top.sv =====
`timescale 1ns / 1ps
// channel | direction | handshake             | payload
// req     | in        | req_valid / req_ready | req_kind, req_rx_value
// rsp     | out       | rsp_valid / rsp_ready | send, payload, finish fields
// csr     | in        | csr_valid / csr_ready | csr_index, csr_data
//
// One beat in, one beat out; each accepted request is registered straight into the result register.
// A new request is taken every cycle while the result register is empty or drained.
// Synchronous reset returns to idle with the register defaults; csr_ready is always high.
// A stalled rsp beat holds req_ready low until it is taken.

module framed_link_receiver_top #(
   parameter int TIMER_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_kind,
   input  logic [7:0]                      req_rx_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_send_valid,
   output logic [7:0]                      rsp_send_value,
   output logic                            rsp_payload_valid,
   output logic [7:0]                      rsp_payload_value,
   output logic [7:0]                      rsp_payload_index,
   output logic                            rsp_finished,
   output logic                            rsp_success,
   output logic [7:0]                      rsp_frame_size,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [flr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [flr_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;
   localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

   typedef enum logic [2:0] {
      PH_IDLE, PH_SOH, PH_LEN, PH_CMP, PH_DATA, PH_CHECK
   } phase_type;

   flr_pkg::cfg_type cfg;

   flr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   phase_type             phase_ff, phase_in;
   logic [7:0]            frame_length_ff, frame_length_in;
   logic [7:0]            bytes_taken_ff, bytes_taken_in;
   logic [7:0]            running_check_ff, running_check_in;
   logic [TIMER_BITS-1:0] wait_count_ff, wait_count_in;

   logic       rsp_valid_ff;
   logic       send_valid_ff, send_valid_in;
   logic [7:0] send_value_ff, send_value_in;
   logic       payload_valid_ff, payload_valid_in;
   logic [7:0] payload_value_ff, payload_value_in;
   logic [7:0] payload_index_ff, payload_index_in;
   logic       finished_ff, finished_in;
   logic       success_ff, success_in;
   logic [7:0] frame_size_ff, frame_size_in;

   logic                  accept;
   logic [TIMER_BITS-1:0] wait_sat;
   logic [7:0]            taken_next;
   logic                  fail;
   logic                  good;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign wait_sat   = (wait_count_ff == TIMER_MAX) ? wait_count_ff
                                                    : wait_count_ff + 1'b1;
   assign taken_next = bytes_taken_ff + 8'd1;

   always_comb begin
      phase_in         = phase_ff;
      frame_length_in  = frame_length_ff;
      bytes_taken_in   = bytes_taken_ff;
      running_check_in = running_check_ff;
      wait_count_in    = wait_count_ff;
      send_valid_in    = 1'b0;
      send_value_in    = 8'd0;
      payload_valid_in = 1'b0;
      payload_value_in = 8'd0;
      payload_index_in = 8'd0;
      finished_in      = 1'b0;
      success_in       = 1'b0;
      frame_size_in    = 8'd0;
      fail             = 1'b0;
      good             = 1'b0;

      if (req_kind == flr_pkg::KIND_START) begin
         phase_in         = PH_SOH;
         frame_length_in  = 8'd0;
         bytes_taken_in   = 8'd0;
         running_check_in = cfg.check_seed;
         wait_count_in    = '0;
         send_valid_in    = 1'b1;
         send_value_in    = cfg.reject_char;
      end else if (phase_ff == PH_IDLE || !(req_kind == flr_pkg::KIND_BYTE ||
                                            req_kind == flr_pkg::KIND_TICK)) begin
         phase_in = phase_ff;
      end else if (req_kind == flr_pkg::KIND_TICK) begin
         if (cfg.timeout_on) begin
            wait_count_in = wait_sat;
            if (CMP_W'(wait_sat) >= CMP_W'(cfg.timeout_ticks) || wait_sat == TIMER_MAX) begin
               fail = 1'b1;
            end
         end
      end else begin
         wait_count_in = '0;
         unique case (phase_ff)
            PH_SOH: begin
               if (req_rx_value != cfg.start_char) fail = 1'b1;
               else phase_in = PH_LEN;
            end
            PH_LEN: begin
               if (req_rx_value > cfg.length_limit) begin
                  fail = 1'b1;
               end else begin
                  frame_length_in = req_rx_value;
                  phase_in        = PH_CMP;
               end
            end
            PH_CMP: begin
               if (req_rx_value != ~frame_length_ff) fail = 1'b1;
               else phase_in = (frame_length_ff == 8'd0) ? PH_CHECK : PH_DATA;
            end
            PH_DATA: begin
               payload_valid_in = 1'b1;
               payload_value_in = req_rx_value;
               payload_index_in = bytes_taken_ff;
               running_check_in = running_check_ff ^ req_rx_value;
               bytes_taken_in   = taken_next;
               if (taken_next >= frame_length_ff) phase_in = PH_CHECK;
            end
            PH_CHECK: begin
               if (req_rx_value == running_check_ff) good = 1'b1;
               else fail = 1'b1;
            end
            default: phase_in = PH_IDLE;
         endcase
      end

      // close the frame on either outcome
      if (fail || good) begin
         send_valid_in = 1'b1;
         send_value_in = good ? cfg.accept_char : cfg.reject_char;
         finished_in   = 1'b1;
         success_in    = good;
         frame_size_in = frame_length_ff;
         phase_in      = PH_IDLE;
         wait_count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         frame_length_ff  <= 8'd0;
         bytes_taken_ff   <= 8'd0;
         running_check_ff <= 8'd0;
         wait_count_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff         <= phase_in;
            frame_length_ff  <= frame_length_in;
            bytes_taken_ff   <= bytes_taken_in;
            running_check_ff <= running_check_in;
            wait_count_ff    <= wait_count_in;
            rsp_valid_ff     <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         send_valid_ff    <= send_valid_in;
         send_value_ff    <= send_value_in;
         payload_valid_ff <= payload_valid_in;
         payload_value_ff <= payload_value_in;
         payload_index_ff <= payload_index_in;
         finished_ff      <= finished_in;
         success_ff       <= success_in;
         frame_size_ff    <= frame_size_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_send_valid    = send_valid_ff;
   assign rsp_send_value    = send_value_ff;
   assign rsp_payload_valid = payload_valid_ff;
   assign rsp_payload_value = payload_value_ff;
   assign rsp_payload_index = payload_index_ff;
   assign rsp_finished      = finished_ff;
   assign rsp_success       = success_ff;
   assign rsp_frame_size    = frame_size_ff;

endmodule

// ===== src/flr_csr.sv =====
`timescale 1ns / 1ps

module flr_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [flr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [flr_pkg::CSR_DATA_W-1:0]   csr_data,
   output flr_pkg::cfg_type                 cfg
);

   flr_pkg::cfg_type cfg_ff;
   flr_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            flr_pkg::REG_START_CHAR:    cfg_in.start_char    = csr_data[7:0];
            flr_pkg::REG_ACCEPT_CHAR:   cfg_in.accept_char   = csr_data[7:0];
            flr_pkg::REG_REJECT_CHAR:   cfg_in.reject_char   = csr_data[7:0];
            flr_pkg::REG_CHECK_SEED:    cfg_in.check_seed    = csr_data[7:0];
            flr_pkg::REG_LENGTH_LIMIT:  cfg_in.length_limit  = csr_data[7:0];
            flr_pkg::REG_TIMEOUT_ON:    cfg_in.timeout_on    = csr_data[0];
            flr_pkg::REG_TIMEOUT_TICKS: cfg_in.timeout_ticks = csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_char    <= 8'd1;
         cfg_ff.accept_char   <= 8'd6;
         cfg_ff.reject_char   <= 8'd21;
         cfg_ff.check_seed    <= 8'd0;
         cfg_ff.length_limit  <= 8'd64;
         cfg_ff.timeout_on    <= 1'b0;
         cfg_ff.timeout_ticks <= 16'd1000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
